// File: rtl/salts_pkg.sv
package salts_pkg;
    localparam int ADDR_W  = 64;
    localparam int LB_W    = 13;
    localparam int SETS_W  = 7;
    localparam int WAYS_W  = 4;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_LINE_BYTES = 2'd0;
    localparam logic [IDX_W-1:0] REG_SETS       = 2'd1;
    localparam logic [IDX_W-1:0] REG_WAYS       = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] quot;
        logic [LB_W-1:0]   rem;
    } div_res_t;
endpackage

// File: rtl/salts_if.sv
interface salts_addr_if;
    logic        valid;
    logic        ready;
    logic [63:0] address;
    modport source (output valid, output address, input ready);
    modport sink (input valid, input address, output ready);
endinterface

interface salts_hit_if;
    logic valid;
    logic ready;
    logic hit;
    modport source (output valid, output hit, input ready);
    modport sink (input valid, input hit, output ready);
endinterface

interface salts_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/salts_div.sv
// Restoring divider, one quotient bit per cycle.
module salts_div
    import salts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ADDR_W-1:0] dividend,
    input  logic [LB_W-1:0]   divisor,
    output logic              done,
    output div_res_t          res
);
    logic [ADDR_W-1:0] q_reg, q_next;
    logic [LB_W:0]     r_reg, r_next;
    logic [LB_W-1:0]   d_reg, d_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [LB_W:0]     shifted;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted = {r_reg[LB_W-1:0], q_reg[ADDR_W-1]};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                r_next = shifted - {1'b0, d_reg};
                q_next = {q_reg[ADDR_W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[ADDR_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign res.quot = q_reg;
    assign res.rem = r_reg[LB_W-1:0];
endmodule

// File: rtl/set_assoc_lru_tag_store.sv
// set_assoc_lru_tag_store: LRU tag store of a set-associative cache.
// Channels: addr_in (sink, one 64-bit address per word), hit_out (source,
// one hit bit per word), cfg (sink, register index + data; writes land at
// once, ready is always high; send them only while the block is idle).
// Per word: a bit-serial divide by line_bytes, a second divide by the set
// count (shared divider), a fill-count read, a tag walk over the set, one
// way per cycle from the tag memory (read data registered), then a reorder
// that writes the set back one way per cycle, last way first.
// One word at a time. The result is registered twice, first in a pending
// register and then in the output register, so the hit word goes valid
// only after the block can take the next address.
// The result sits in an output register; the next address is taken while
// it waits, the following one stalls until it is taken.
// Reset clears the configuration (line 64, 64 sets, 8 ways) and the per-set
// valid bits, so every fill count reads as zero; the tag and fill memories
// themselves are not cleared, no clearing pass.
module set_assoc_lru_tag_store
    import salts_pkg::*;
#(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8
)
(
    input  logic clk,
    input  logic rst_n,
    salts_addr_if.sink   addr_in,
    salts_hit_if.source  hit_out,
    salts_cfg_if.sink    cfg
);
    localparam int SET_IW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_IW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int FILL_W = $clog2(MAX_WAYS + 1);
    localparam int DEPTH  = MAX_SETS * MAX_WAYS;
    localparam int MEM_IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV1 = 3'd1;
    localparam logic [2:0] ST_DIV2 = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_SHFT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;
    localparam logic [2:0] ST_FILL = 3'd6;

    logic [LB_W-1:0]   lb_reg;
    logic [SETS_W-1:0] sets_reg;
    logic [WAYS_W-1:0] ways_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lb_reg <= LB_W'(64);
            sets_reg <= SETS_W'(64);
            ways_reg <= WAYS_W'(8);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_LINE_BYTES: lb_reg <= cfg.data[LB_W-1:0];
                REG_SETS:       sets_reg <= cfg.data[SETS_W-1:0];
                REG_WAYS:       ways_reg <= cfg.data[WAYS_W-1:0];
                default: ;
            endcase
        end
    end
    assign cfg.ready = 1'b1;

    // effective configuration, clamped
    logic [LB_W-1:0] lb_eff, ns_eff;
    logic [FILL_W-1:0] nw_eff;
    always_comb
    begin
        lb_eff = (lb_reg == '0) ? LB_W'(1) : lb_reg;
        if (sets_reg == '0)
            ns_eff = LB_W'(1);
        else if (32'(sets_reg) > MAX_SETS)
            ns_eff = LB_W'(MAX_SETS);
        else
            ns_eff = LB_W'(sets_reg);
        if (ways_reg == '0)
            nw_eff = FILL_W'(1);
        else if (32'(ways_reg) > MAX_WAYS)
            nw_eff = FILL_W'(MAX_WAYS);
        else
            nw_eff = FILL_W'(ways_reg);
    end

    logic [2:0]          state_reg;
    logic [ADDR_W-1:0]   tag_reg;
    logic [SET_IW-1:0]   set_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   pos_reg;
    logic                found_reg;
    logic                rd_pend_reg;
    logic [FILL_W-1:0]   fill_mem [MAX_SETS];
    logic [MAX_SETS-1:0] fill_vld_reg;
    logic [ADDR_W-1:0]   tags_mem [DEPTH];
    logic [ADDR_W-1:0]   rd_data_reg;
    logic [FILL_W-1:0]   rd_way_reg;
    logic                out_valid_reg;
    logic                out_hit_reg;
    logic                res_pend_reg;
    logic                res_hit_reg;
    logic                walk_hit;
    logic                walk_miss;
    logic [FILL_W-1:0]   keep;

    logic                div_start;
    logic [ADDR_W-1:0]   div_a;
    logic [LB_W-1:0]     div_b;
    logic                div_done;
    div_res_t            div_res;

    salts_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .res(div_res)
    );

    // Address of way w within the current set.
    function automatic logic [MEM_IW-1:0] maddr(input logic [SET_IW-1:0] s,
                                                input logic [FILL_W-1:0] w);
        maddr = MEM_IW'(s * MAX_WAYS + w);
    endfunction

    logic accept;
    assign accept = addr_in.valid && addr_in.ready;
    assign addr_in.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        div_start = 1'b0;
        div_a = addr_in.address;
        div_b = lb_eff;
        if (accept)
            div_start = 1'b1;
        else if (state_reg == ST_DIV1 && div_done)
        begin
            div_start = 1'b1;
            div_a = div_res.quot;
            div_b = ns_eff;
        end
    end

    // walk outcome; a miss keeps at most nw_eff tags
    always_comb
    begin
        walk_hit = (state_reg == ST_WALK) && rd_pend_reg && (rd_data_reg == tag_reg);
        walk_miss = (state_reg == ST_WALK) && !walk_hit && (pos_reg >= fill_reg);
        keep = (fill_reg + FILL_W'(1) > nw_eff) ? nw_eff : fill_reg + FILL_W'(1);
    end

    // walk reads way pos_reg; data arrives next cycle. Shift phase moves
    // entry pos-1 to pos, reading one ahead.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WALK)
        begin
            rd_data_reg <= tags_mem[maddr(set_reg, pos_reg)];
            rd_way_reg <= pos_reg;
        end
        else if (state_reg == ST_SHFT)
        begin
            if (pos_reg != '0)
                rd_data_reg <= tags_mem[maddr(set_reg, pos_reg - FILL_W'(1))];
            rd_way_reg <= pos_reg;
        end
        if (state_reg == ST_SHFT && rd_pend_reg)
        begin
            tags_mem[maddr(set_reg, rd_way_reg)] <=
                (rd_way_reg == '0) ? tag_reg : rd_data_reg;
        end
        if (state_reg == ST_DIV2 && div_done)
            tag_reg <= div_res.quot;
        // a set never missed into reads as empty
        if (state_reg == ST_FILL)
            fill_reg <= fill_vld_reg[set_reg] ? fill_mem[set_reg] : '0;
        if (walk_miss)
            fill_mem[set_reg] <= keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            set_reg <= '0;
            pos_reg <= '0;
            found_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_hit_reg <= 1'b0;
            res_pend_reg <= 1'b0;
            res_hit_reg <= 1'b0;
            fill_vld_reg <= '0;
        end
        else
        begin
            if (res_pend_reg && (!out_valid_reg || hit_out.ready))
            begin
                out_valid_reg <= 1'b1;
                out_hit_reg <= res_hit_reg;
                res_pend_reg <= 1'b0;
            end
            else if (out_valid_reg && hit_out.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                        state_reg <= ST_DIV1;
                end
                ST_DIV1:
                begin
                    if (div_done)
                        state_reg <= ST_DIV2;
                end
                ST_DIV2:
                begin
                    if (div_done)
                    begin
                        set_reg <= SET_IW'(div_res.rem);
                        pos_reg <= '0;
                        found_reg <= 1'b0;
                        rd_pend_reg <= 1'b0;
                        state_reg <= ST_FILL;
                    end
                end
                ST_FILL:
                begin
                    state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    // compare last read; stop on match or after fill reads
                    if (walk_hit)
                    begin
                        found_reg <= 1'b1;
                        pos_reg <= rd_way_reg;
                        rd_pend_reg <= 1'b0;
                        state_reg <= ST_SHFT;
                    end
                    else if (walk_miss)
                    begin
                        // miss: shift range ends at keep-1
                        pos_reg <= keep - FILL_W'(1);
                        fill_vld_reg[set_reg] <= 1'b1;
                        rd_pend_reg <= 1'b0;
                        state_reg <= ST_SHFT;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        pos_reg <= pos_reg + FILL_W'(1);
                    end
                end
                ST_SHFT:
                begin
                    // each cycle: read pos-1, next cycle write it at pos
                    if (rd_pend_reg && rd_way_reg == '0)
                    begin
                        rd_pend_reg <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        if (pos_reg != '0)
                            pos_reg <= pos_reg - FILL_W'(1);
                    end
                end
                ST_DONE:
                begin
                    if (!res_pend_reg)
                    begin
                        res_pend_reg <= 1'b1;
                        res_hit_reg <= found_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign hit_out.valid = out_valid_reg;
    assign hit_out.hit = out_hit_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hit_out.valid && !hit_out.ready |=> hit_out.valid && $stable(hit_out.hit));
    a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2));
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> fill_reg <= FILL_W'(MAX_WAYS));
    a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHFT |-> pos_reg < FILL_W'(MAX_WAYS));
endmodule
